// File: design/tcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcb_pkg;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] code;
		logic [7:0] repeat_count;
		logic [6:0] read_col;
		logic [5:0] read_row;
	} in_item_t;

	typedef struct packed {
		logic [6:0] cursor_col;
		logic [5:0] cursor_row;
		logic [7:0] cell_value;
	} out_item_t;

	localparam logic [1:0] OP_KEY  = 2'd0;
	localparam logic [1:0] OP_CHAR = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [7:0] KEY_HOME   = 8'd0;
	localparam logic [7:0] KEY_END    = 8'd1;
	localparam logic [7:0] KEY_PGUP   = 8'd2;
	localparam logic [7:0] KEY_PGDN   = 8'd3;
	localparam logic [7:0] KEY_LEFT   = 8'd4;
	localparam logic [7:0] KEY_RIGHT  = 8'd5;
	localparam logic [7:0] KEY_UP     = 8'd6;
	localparam logic [7:0] KEY_DOWN   = 8'd7;
	localparam logic [7:0] KEY_DELETE = 8'd8;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int COLS_RESET = 80;
	localparam int ROWS_RESET = 25;

	// character classes
	localparam logic [2:0] CK_PLAIN = 3'd0;
	localparam logic [2:0] CK_BS    = 3'd1;
	localparam logic [2:0] CK_TAB   = 3'd2;
	localparam logic [2:0] CK_LF    = 3'd3;
	localparam logic [2:0] CK_CR    = 3'd4;
	localparam logic [2:0] CK_ESC   = 3'd5;

	// datapath operations
	localparam logic [3:0] DP_NOP       = 4'd0;
	localparam logic [3:0] DP_LOAD      = 4'd1;
	localparam logic [3:0] DP_KEY       = 4'd2;
	localparam logic [3:0] DP_DEL_INIT  = 4'd3;
	localparam logic [3:0] DP_DEL_SPACE = 4'd4;
	localparam logic [3:0] DP_DEL_COPY  = 4'd5;
	localparam logic [3:0] DP_BS        = 4'd6;
	localparam logic [3:0] DP_PUT       = 4'd7;
	localparam logic [3:0] DP_PUT_SPACE = 4'd8;
	localparam logic [3:0] DP_LF        = 4'd9;
	localparam logic [3:0] DP_CR        = 4'd10;
	localparam logic [3:0] DP_CLR_INIT  = 4'd11;
	localparam logic [3:0] DP_CLR_STEP  = 4'd12;
	localparam logic [3:0] DP_FINISH    = 4'd13;
	localparam logic [3:0] DP_RD_CELL   = 4'd14;

	typedef struct packed {
		logic [3:0] op;
		logic       rep_done;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [2:0] kind;
		logic       key_move;
		logic       key_del;
		logic       cnt_zero;
		logic       cnt_last;
		logic       x_zero;
		logic       del_last;
		logic       clr_last;
		logic       tab_stop;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: design/text_terminal_cell_buffer.sv
`timescale 1ns / 1ps
`default_nettype none

// Character-cell text buffer with cursor. An item is taken when start is high and busy
// low; its one result appears on result for a single cycle with done high and must be
// captured then. Every item runs alone through one controller and one single-write RAM
// port, whether a key move, a read, a character event repeated repeat_count times, a
// delete or backspace that shifts the rest of the row left, or an escape with the sweep
// that writes spaces over the rows and columns in use. The same sweep runs after reset
// and after every write of a size register; busy stays high during it, and configuration
// writes are taken meanwhile.
module text_terminal_cell_buffer #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64,
	parameter int TAB_STEP = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire tcb_pkg::in_item_t item,
	output tcb_pkg::out_item_t     result,
	output logic                   done,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int COLS_RST = (tcb_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS : tcb_pkg::COLS_RESET;
	localparam int ROWS_RST = (tcb_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS : tcb_pkg::ROWS_RESET;
	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	logic [CW-1:0] cols_q;
	logic [RW-1:0] rows_q;
	logic          cfg_we;
	logic [7:0]    wr_cols;
	logic [6:0]    wr_rows;
	logic [CW-1:0] cols_clamp;
	logic [RW-1:0] rows_clamp;

	tcb_pkg::dp_cmd_t  cmd;
	tcb_pkg::dp_stat_t stat;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign wr_cols = pwdata[7:0];
	assign wr_rows = pwdata[6:0];

	always_comb begin
		if (wr_cols == 8'd0) begin
			cols_clamp = CW'(1);
		end else if (32'(wr_cols) > MAX_COLS) begin
			cols_clamp = CW'(MAX_COLS);
		end else begin
			cols_clamp = CW'(wr_cols);
		end
		if (wr_rows == 7'd0) begin
			rows_clamp = RW'(1);
		end else if (32'(wr_rows) > MAX_ROWS) begin
			rows_clamp = RW'(MAX_ROWS);
		end else begin
			rows_clamp = RW'(wr_rows);
		end
		prdata = (paddr[2] == REG_ROWS) ? 32'(rows_q) : 32'(cols_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CW'(COLS_RST);
			rows_q <= RW'(ROWS_RST);
		end else if (cfg_we) begin
			if (paddr[2] == REG_COLS) begin
				cols_q <= cols_clamp;
			end else begin
				rows_q <= rows_clamp;
			end
		end
	end

	tcb_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cfg_we(cfg_we),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	tcb_dp #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS),
		.TAB_STEP(TAB_STEP),
		.CW      (CW),
		.RW      (RW)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.cfg_we(cfg_we),
		.cols  (cols_q),
		.rows  (rows_q),
		.item  (item),
		.stat  (stat),
		.result(result),
		.done  (done)
	);

endmodule

`default_nettype wire

// File: design/tcb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: design/tcb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              cfg_we,
	input  wire tcb_pkg::dp_stat_t stat,
	output tcb_pkg::dp_cmd_t       cmd,
	output logic                   busy
);

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DISP   = 4'd2;
	localparam logic [3:0] S_CHAR   = 4'd3;
	localparam logic [3:0] S_TAB    = 4'd4;
	localparam logic [3:0] S_DEL_RD = 4'd5;
	localparam logic [3:0] S_DEL_WR = 4'd6;
	localparam logic [3:0] S_WIPE   = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [3:0] rep_next;

	assign rep_next = stat.cnt_last ? S_DONE : S_CHAR;
	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op = tcb_pkg::DP_NOP;
		cmd.rep_done = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.op = tcb_pkg::DP_CLR_STEP;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.op = tcb_pkg::DP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.opcode)
					tcb_pkg::OP_KEY: begin
						if (stat.key_move) begin
							cmd.op = tcb_pkg::DP_KEY;
							state_d = S_DONE;
						end else if (stat.key_del) begin
							cmd.op = tcb_pkg::DP_DEL_INIT;
							state_d = S_DEL_RD;
						end else begin
							state_d = S_DONE;
						end
					end
					tcb_pkg::OP_CHAR: begin
						state_d = stat.cnt_zero ? S_DONE : S_CHAR;
					end
					tcb_pkg::OP_READ: begin
						cmd.op = tcb_pkg::DP_RD_CELL;
						state_d = S_DONE;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_CHAR: begin
				case (stat.kind)
					tcb_pkg::CK_BS: begin
						if (stat.x_zero) begin
							cmd.rep_done = 1'b1;
							state_d = rep_next;
						end else begin
							cmd.op = tcb_pkg::DP_BS;
							state_d = S_DEL_RD;
						end
					end
					tcb_pkg::CK_TAB: begin
						state_d = S_TAB;
					end
					tcb_pkg::CK_LF: begin
						cmd.op = tcb_pkg::DP_LF;
						cmd.rep_done = 1'b1;
						state_d = rep_next;
					end
					tcb_pkg::CK_CR: begin
						cmd.op = tcb_pkg::DP_CR;
						cmd.rep_done = 1'b1;
						state_d = rep_next;
					end
					tcb_pkg::CK_ESC: begin
						cmd.op = tcb_pkg::DP_CLR_INIT;
						state_d = S_WIPE;
					end
					default: begin
						cmd.op = tcb_pkg::DP_PUT;
						cmd.rep_done = 1'b1;
						state_d = rep_next;
					end
				endcase
			end
			S_TAB: begin
				cmd.op = tcb_pkg::DP_PUT_SPACE;
				if (stat.tab_stop) begin
					cmd.rep_done = 1'b1;
					state_d = rep_next;
				end
			end
			S_DEL_RD: begin
				if (stat.del_last) begin
					cmd.op = tcb_pkg::DP_DEL_SPACE;
					if (stat.opcode == tcb_pkg::OP_KEY) begin
						state_d = S_DONE;
					end else begin
						cmd.rep_done = 1'b1;
						state_d = rep_next;
					end
				end else begin
					state_d = S_DEL_WR;
				end
			end
			S_DEL_WR: begin
				cmd.op = tcb_pkg::DP_DEL_COPY;
				state_d = S_DEL_RD;
			end
			S_WIPE: begin
				// further escapes in the same item change nothing
				cmd.op = tcb_pkg::DP_CLR_STEP;
				if (stat.clr_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.op = tcb_pkg::DP_FINISH;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (cfg_we) begin
			state_d = S_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: design/tcb_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tcb_dp #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64,
	parameter int TAB_STEP = 8,
	parameter int CW       = $clog2(MAX_COLS + 1),
	parameter int RW       = $clog2(MAX_ROWS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tcb_pkg::dp_cmd_t  cmd,
	input  wire logic              cfg_we,
	input  wire logic [CW-1:0]     cols,
	input  wire logic [RW-1:0]     rows,
	input  wire tcb_pkg::in_item_t item,
	output tcb_pkg::dp_stat_t      stat,
	output tcb_pkg::out_item_t     result,
	output logic                   done
);

	localparam int XW = $clog2(MAX_COLS);
	localparam int YW = $clog2(MAX_ROWS);
	localparam int AW = XW + YW;

	tcb_pkg::in_item_t item_q;
	logic [XW-1:0] cur_x_q;
	logic [YW-1:0] cur_y_q;
	logic [XW-1:0] ptr_q;
	logic [YW-1:0] clr_y_q;
	logic [7:0]    cnt_q;

	logic [XW:0]   x_inc;
	logic [YW:0]   y_inc;
	logic          x_wrap;
	logic          y_wrap;
	logic [XW-1:0] x_put;
	logic [YW-1:0] y_next;
	logic [XW-1:0] x_last;
	logic [YW-1:0] y_last;
	logic [XW-1:0] ptr_inc;
	logic          rd_in_range;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	logic [2**XW-1:0] tab_stop;

	for (genvar i = 0; i < 2**XW; i++) begin : g_tab
		assign tab_stop[i] = ((i % TAB_STEP) == 0);
	end

	assign x_inc   = {1'b0, cur_x_q} + 1'b1;
	assign y_inc   = {1'b0, cur_y_q} + 1'b1;
	assign x_wrap  = (x_inc >= (XW+1)'(cols));
	assign y_wrap  = (y_inc >= (YW+1)'(rows));
	assign x_put   = x_wrap ? '0 : x_inc[XW-1:0];
	assign y_next  = y_wrap ? '0 : y_inc[YW-1:0];
	assign x_last  = XW'(cols - 1'b1);
	assign y_last  = YW'(rows - 1'b1);
	assign ptr_inc = ptr_q + 1'b1;
	assign rd_in_range = (16'(item_q.read_col) < 16'(cols)) &&
		(16'(item_q.read_row) < 16'(rows));

	always_comb begin
		case (item_q.code)
			tcb_pkg::CH_BS:  stat.kind = tcb_pkg::CK_BS;
			tcb_pkg::CH_TAB: stat.kind = tcb_pkg::CK_TAB;
			tcb_pkg::CH_LF:  stat.kind = tcb_pkg::CK_LF;
			tcb_pkg::CH_CR:  stat.kind = tcb_pkg::CK_CR;
			tcb_pkg::CH_ESC: stat.kind = tcb_pkg::CK_ESC;
			default:         stat.kind = tcb_pkg::CK_PLAIN;
		endcase
		stat.opcode   = item_q.opcode;
		stat.key_move = (item_q.code < tcb_pkg::KEY_DELETE);
		stat.key_del  = (item_q.code == tcb_pkg::KEY_DELETE);
		stat.cnt_zero = (cnt_q == 8'd0);
		stat.cnt_last = (cnt_q == 8'd1);
		stat.x_zero   = (cur_x_q == '0);
		stat.del_last = (ptr_q == x_last);
		stat.clr_last = (ptr_q == x_last) && (clr_y_q == y_last);
		stat.tab_stop = tab_stop[x_put];
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {cur_y_q, ptr_q};
		ram_wdata = tcb_pkg::CH_SPACE;
		case (cmd.op)
			tcb_pkg::DP_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = {cur_y_q, cur_x_q};
				ram_wdata = item_q.code;
			end
			tcb_pkg::DP_PUT_SPACE: begin
				ram_we    = 1'b1;
				ram_waddr = {cur_y_q, cur_x_q};
			end
			tcb_pkg::DP_DEL_SPACE: begin
				ram_we = 1'b1;
			end
			tcb_pkg::DP_DEL_COPY: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			tcb_pkg::DP_CLR_STEP: begin
				ram_we    = 1'b1;
				ram_waddr = {clr_y_q, ptr_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
		if (cmd.op == tcb_pkg::DP_RD_CELL) begin
			ram_raddr = {YW'(item_q.read_row), XW'(item_q.read_col)};
		end else begin
			ram_raddr = {cur_y_q, ptr_inc};
		end
	end

	tcb_ram #(
		.WIDTH(8),
		.DEPTH(2**AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			ptr_q   <= '0;
			clr_y_q <= '0;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= (cmd.op == tcb_pkg::DP_FINISH);
			if (cmd.rep_done) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cfg_we) begin
				cur_x_q <= '0;
				cur_y_q <= '0;
				ptr_q   <= '0;
				clr_y_q <= '0;
			end else begin
				case (cmd.op)
					tcb_pkg::DP_LOAD: begin
						cnt_q <= item.repeat_count;
					end
					tcb_pkg::DP_KEY: begin
						case (item_q.code)
							tcb_pkg::KEY_HOME: cur_x_q <= '0;
							tcb_pkg::KEY_END:  cur_x_q <= x_last;
							tcb_pkg::KEY_PGUP: cur_y_q <= '0;
							tcb_pkg::KEY_PGDN: cur_y_q <= y_last;
							tcb_pkg::KEY_LEFT: begin
								if (cur_x_q != '0) begin
									cur_x_q <= cur_x_q - 1'b1;
								end
							end
							tcb_pkg::KEY_RIGHT: begin
								if (!x_wrap) begin
									cur_x_q <= x_inc[XW-1:0];
								end
							end
							tcb_pkg::KEY_UP: begin
								if (cur_y_q != '0) begin
									cur_y_q <= cur_y_q - 1'b1;
								end
							end
							tcb_pkg::KEY_DOWN: begin
								if (!y_wrap) begin
									cur_y_q <= y_inc[YW-1:0];
								end
							end
							default: begin
								cur_x_q <= cur_x_q;
							end
						endcase
					end
					tcb_pkg::DP_DEL_INIT: begin
						ptr_q <= cur_x_q;
					end
					tcb_pkg::DP_BS: begin
						cur_x_q <= cur_x_q - 1'b1;
						ptr_q   <= cur_x_q - 1'b1;
					end
					tcb_pkg::DP_DEL_COPY: begin
						ptr_q <= ptr_inc;
					end
					tcb_pkg::DP_PUT, tcb_pkg::DP_PUT_SPACE: begin
						cur_x_q <= x_put;
						if (x_wrap) begin
							cur_y_q <= y_next;
						end
					end
					tcb_pkg::DP_LF: begin
						cur_y_q <= y_next;
					end
					tcb_pkg::DP_CR: begin
						cur_x_q <= '0;
						cur_y_q <= y_next;
					end
					tcb_pkg::DP_CLR_INIT: begin
						cur_x_q <= '0;
						cur_y_q <= '0;
						ptr_q   <= '0;
						clr_y_q <= '0;
					end
					tcb_pkg::DP_CLR_STEP: begin
						if (ptr_q == x_last) begin
							ptr_q   <= '0;
							clr_y_q <= clr_y_q + 1'b1;
						end else begin
							ptr_q <= ptr_inc;
						end
					end
					default: begin
						ptr_q <= ptr_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == tcb_pkg::DP_LOAD) begin
			item_q <= item;
		end
		if (cmd.op == tcb_pkg::DP_FINISH) begin
			result.cursor_col <= 7'(cur_x_q);
			result.cursor_row <= 6'(cur_y_q);
			if (item_q.opcode == tcb_pkg::OP_READ) begin
				result.cell_value <= rd_in_range ? ram_rdata : tcb_pkg::CH_SPACE;
			end else begin
				result.cell_value <= 8'd0;
			end
		end
	end

endmodule

`default_nettype wire

// File: verif/text_terminal_cell_buffer_checker.sv
`timescale 1ns / 1ps

module text_terminal_cell_buffer_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire tcb_pkg::in_item_t item,
	input  wire tcb_pkg::out_item_t result,
	input  wire logic              done,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic              pready,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output int                     fail_count,
	output int                     pending
);

	localparam int GRID_COLS = 128;
	localparam int GRID_ROWS = 64;
	localparam int TAB_WIDTH = 8;
	localparam logic [2:0] ADDR_COLUMNS = 3'd0;
	localparam logic [2:0] ADDR_ROWS    = 3'd4;

	logic [7:0] grid [0:GRID_COLS*GRID_ROWS-1];
	int unsigned cx, cy, n_cols, n_rows;
	tcb_pkg::out_item_t response_q [$];
	tcb_pkg::out_item_t want;
	int errs;

	function automatic int unsigned fit_size(int unsigned v, int unsigned lim);
		if (v == 0) return 1;
		if (v > lim) return lim;
		return v;
	endfunction

	function automatic void wipe_grid();
		int i;
		for (i = 0; i < GRID_COLS*GRID_ROWS; i++) grid[i] = tcb_pkg::CH_SPACE;
		cx = 0;
		cy = 0;
	endfunction

	function automatic void next_line();
		cy++;
		if (cy >= n_rows) cy = 0;
	endfunction

	function automatic void close_gap();
		int unsigned x;
		for (x = cx; x + 1 < n_cols; x++)
			grid[cy*GRID_COLS + x] = grid[cy*GRID_COLS + x + 1];
		grid[cy*GRID_COLS + n_cols - 1] = tcb_pkg::CH_SPACE;
	endfunction

	function automatic void type_char(logic [7:0] c);
		grid[cy*GRID_COLS + cx] = c;
		cx++;
		if (cx >= n_cols) begin
			cx = 0;
			next_line();
		end
	endfunction

	function automatic void press_key(logic [7:0] k);
		case (k)
			tcb_pkg::KEY_HOME:   cx = 0;
			tcb_pkg::KEY_END:    cx = n_cols - 1;
			tcb_pkg::KEY_PGUP:   cy = 0;
			tcb_pkg::KEY_PGDN:   cy = n_rows - 1;
			tcb_pkg::KEY_LEFT:   if (cx > 0) cx--;
			tcb_pkg::KEY_RIGHT:  if (cx + 1 < n_cols) cx++;
			tcb_pkg::KEY_UP:     if (cy > 0) cy--;
			tcb_pkg::KEY_DOWN:   if (cy + 1 < n_rows) cy++;
			tcb_pkg::KEY_DELETE: close_gap();
			default: ;
		endcase
	endfunction

	function automatic void edit_char(logic [7:0] c);
		case (c)
			tcb_pkg::CH_BS: begin
				if (cx > 0) begin
					cx--;
					close_gap();
				end
			end
			tcb_pkg::CH_TAB: begin
				do type_char(tcb_pkg::CH_SPACE); while (cx % TAB_WIDTH != 0);
			end
			tcb_pkg::CH_LF: next_line();
			tcb_pkg::CH_CR: begin
				cx = 0;
				next_line();
			end
			tcb_pkg::CH_ESC: wipe_grid();
			default: type_char(c);
		endcase
	endfunction

	function automatic tcb_pkg::out_item_t terminal_response(tcb_pkg::in_item_t it);
		tcb_pkg::out_item_t r;
		int i;
		r.cell_value = '0;
		case (it.opcode)
			tcb_pkg::OP_KEY: press_key(it.code);
			tcb_pkg::OP_CHAR: for (i = 0; i < it.repeat_count; i++) edit_char(it.code);
			tcb_pkg::OP_READ: begin
				if (it.read_col < n_cols && it.read_row < n_rows)
					r.cell_value = grid[it.read_row*GRID_COLS + it.read_col];
				else
					r.cell_value = tcb_pkg::CH_SPACE;
			end
			default: ;
		endcase
		r.cursor_col = cx[6:0];
		r.cursor_row = cy[5:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_cols = tcb_pkg::COLS_RESET;
			n_rows = tcb_pkg::ROWS_RESET;
			wipe_grid();
			response_q.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_COLUMNS) begin
					n_cols = fit_size(32'(pwdata[7:0]), GRID_COLS);
					wipe_grid();
				end else if (paddr == ADDR_ROWS) begin
					n_rows = fit_size(32'(pwdata[6:0]), GRID_ROWS);
					wipe_grid();
				end
			end
			if (start && !busy) response_q.push_back(terminal_response(item));
			if (done) begin
				if (response_q.size() == 0) begin
					errs++;
					$error("result with no transfer pending: col %0d row %0d cell %0h",
						result.cursor_col, result.cursor_row, result.cell_value);
				end else begin
					want = response_q.pop_front();
					if (result.cursor_col !== want.cursor_col) begin
						errs++;
						$error("cursor_col expected %0d actual %0d",
							want.cursor_col, result.cursor_col);
					end
					if (result.cursor_row !== want.cursor_row) begin
						errs++;
						$error("cursor_row expected %0d actual %0d",
							want.cursor_row, result.cursor_row);
					end
					if (result.cell_value !== want.cell_value) begin
						errs++;
						$error("cell_value expected %0h actual %0h",
							want.cell_value, result.cell_value);
					end
				end
			end
			fail_count <= errs;
			pending <= response_q.size();
		end
	end

endmodule

// File: verif/text_terminal_cell_buffer_test.sv
`timescale 1ns / 1ps

module text_terminal_cell_buffer_test;

	localparam int QUIET_LIMIT     = 100000;
	localparam int ITEMS_PER_PHASE = 130;
	localparam int PHASES          = 9;
	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam logic [2:0] ADDR_COLUMNS = 3'd0;
	localparam logic [2:0] ADDR_ROWS    = 3'd4;

	// size writes for phases 1..8; zero and oversize values get clamped
	localparam int COL_WR [PHASES-1] = '{0, 255, 8, 3, 128, 1, 17, 80};
	localparam int ROW_WR [PHASES-1] = '{0, 127, 4, 2, 1, 64, 9, 25};

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               start   = 1'b0;
	tcb_pkg::in_item_t  item    = '0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [2:0]         paddr   = '0;
	logic [31:0]        pwdata  = '0;
	logic               busy, done, pready;
	tcb_pkg::out_item_t result;
	logic [31:0]        prdata;
	int                 fail_count, pending;
	int                 quiet = 0;
	int                 eff_cols = tcb_pkg::COLS_RESET;
	int                 eff_rows = tcb_pkg::ROWS_RESET;
	logic               steady = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	text_terminal_cell_buffer dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .item(item),
		.result(result), .done(done),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	text_terminal_cell_buffer_checker check (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .item(item),
		.result(result), .done(done),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	task automatic send_item(input tcb_pkg::in_item_t it);
		if (!steady && $urandom_range(0, 99) < 24) begin
			start <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 30 : 4)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
	endtask

	function automatic tcb_pkg::in_item_t mk(input logic [1:0] op, input logic [7:0] code,
			input logic [7:0] rep, input logic [6:0] rc, input logic [5:0] rr);
		tcb_pkg::in_item_t it;
		it.opcode = op;
		it.code = code;
		it.repeat_count = rep;
		it.read_col = rc;
		it.read_row = rr;
		return it;
	endfunction

	function automatic tcb_pkg::in_item_t random_keystroke();
		tcb_pkg::in_item_t it;
		int pick;
		it = tcb_pkg::in_item_t'($urandom);
		pick = int'($urandom_range(0, 99));
		if (pick < 35) begin
			it.opcode = tcb_pkg::OP_CHAR;
			it.code = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(8'h20, 8'h7e));
		end else if (pick < 60) begin
			it.opcode = tcb_pkg::OP_KEY;
			it.code = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(9, 255))
				: 8'($urandom_range(0, 8));
		end else if (pick < 85) begin
			it.opcode = tcb_pkg::OP_READ;
			it.read_col = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(0, eff_cols - 1))
				: 7'($urandom_range(0, 127));
			it.read_row = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, eff_rows - 1))
				: 6'($urandom_range(0, 63));
		end else if (pick < 95) begin
			it.opcode = tcb_pkg::OP_CHAR;
			case ($urandom_range(0, 3))
				0: it.code = tcb_pkg::CH_BS;
				1: it.code = tcb_pkg::CH_TAB;
				2: it.code = tcb_pkg::CH_LF;
				default: it.code = tcb_pkg::CH_CR;
			endcase
		end else if (pick < 97) begin
			it.opcode = tcb_pkg::OP_CHAR;
			it.code = tcb_pkg::CH_ESC;
		end else begin
			it.opcode = OP_UNUSED;
		end
		if (it.opcode == tcb_pkg::OP_CHAR) begin
			// a clear costs a grid sweep and a backspace a row shift; keep them short on big grids
			if (it.code == tcb_pkg::CH_ESC)
				it.repeat_count = (eff_cols * eff_rows > 256) ? 8'($urandom_range(0, 2))
					: 8'($urandom_range(0, 255));
			else if (it.code == tcb_pkg::CH_BS && eff_cols > 16)
				it.repeat_count = 8'($urandom_range(0, 8));
			else begin
				pick = int'($urandom_range(0, 99));
				it.repeat_count = (pick < 75) ? 8'($urandom_range(0, 4))
					: (pick < 95) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(0, 255));
			end
		end
		return it;
	endfunction

	initial begin
		int ph, n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				send_item(mk(tcb_pkg::OP_READ, 8'h00, 8'h00, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_CHAR, 8'h41, 8'd1, 7'd127, 6'd63));
				send_item(mk(tcb_pkg::OP_CHAR, 8'h00, 8'd1, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_CHAR, 8'hFF, 8'd3, 7'd5, 6'd2));
				send_item(mk(tcb_pkg::OP_CHAR, 8'h78, 8'd0, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_KEY, tcb_pkg::KEY_LEFT, 8'hFF, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_KEY, tcb_pkg::KEY_RIGHT, 8'd0, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_KEY, tcb_pkg::KEY_END, 8'd0, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_KEY, tcb_pkg::KEY_RIGHT, 8'd0, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_KEY, tcb_pkg::KEY_HOME, 8'd0, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_KEY, tcb_pkg::KEY_DELETE, 8'd0, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_KEY, tcb_pkg::KEY_LEFT, 8'd0, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_KEY, tcb_pkg::KEY_UP, 8'd0, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_KEY, tcb_pkg::KEY_PGDN, 8'd0, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_KEY, tcb_pkg::KEY_DOWN, 8'd0, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_KEY, tcb_pkg::KEY_PGUP, 8'd0, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_KEY, tcb_pkg::KEY_DOWN, 8'd0, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_KEY, 8'd9, 8'd0, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_KEY, 8'hFF, 8'hFF, 7'd127, 6'd63));
				send_item(mk(tcb_pkg::OP_CHAR, tcb_pkg::CH_TAB, 8'd2, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_CHAR, tcb_pkg::CH_BS, 8'd1, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_CHAR, tcb_pkg::CH_LF, 8'd30, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_CHAR, tcb_pkg::CH_CR, 8'd1, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_CHAR, 8'h51, 8'd255, 7'd0, 6'd0));
				send_item(mk(tcb_pkg::OP_READ, 8'h00, 8'h00, 7'd1, 6'd0));
				send_item(mk(tcb_pkg::OP_READ, 8'h00, 8'h00, 7'd79, 6'd24));
				send_item(mk(tcb_pkg::OP_READ, 8'hFF, 8'hFF, 7'd127, 6'd63));
				send_item(mk(OP_UNUSED, 8'hFF, 8'hFF, 7'd127, 6'd63));
				send_item(mk(tcb_pkg::OP_CHAR, tcb_pkg::CH_ESC, 8'd1, 7'd0, 6'd0));
			end else begin
				drain();
				reg_write(ADDR_COLUMNS, COL_WR[ph-1]);
				reg_write(ADDR_ROWS, ROW_WR[ph-1]);
				eff_cols = (COL_WR[ph-1] == 0) ? 1 : (COL_WR[ph-1] > 128) ? 128 : COL_WR[ph-1];
				eff_rows = (ROW_WR[ph-1] == 0) ? 1 : (ROW_WR[ph-1] > 64) ? 64 : ROW_WR[ph-1];
				@(posedge clk);
				while (busy) @(posedge clk);
			end
			steady = (ph == 3);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) == 0) drain();
				send_item(random_keystroke());
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
design/tcb_pkg.sv
design/tcb_ram.sv
design/tcb_ctrl.sv
design/tcb_dp.sv
design/text_terminal_cell_buffer.sv
verif/text_terminal_cell_buffer_checker.sv
verif/text_terminal_cell_buffer_test.sv
